@@ rtl/pal_pkg.sv @@
// ----------------------------------------------------------------------------
// pal_pkg
// shared types, codes and widths of the positional array list
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int ACT_W = 2;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;
    localparam int CNT_W = 7;

    // request: action, position, value_in -> 41 bits, padded to 48
    localparam int IN_TDATA_W  = 48;
    // result: status, value_out, found_position, count, is_empty -> 49 bits, padded to 56
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [STS_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic walk;
        logic write_val;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic req_fail;
        logic walk_done;
        logic is_insert;
    } t_stat;

endpackage

@@ rtl/positional_array_list.sv @@
// ----------------------------------------------------------------------------
// positional_array_list
// fixed-capacity ordered list of signed 32-bit values, 1-based positions
// ----------------------------------------------------------------------------
// usage:
//   requests come in on the s-side stream (insert, delete, find, read), one
//   at a time; each gives exactly one result on the m-side stream.
//   o_s_tready is high only while no request is in work.
// storage and sequencing:
//   the entries live in a ram with one write and one registered read port;
//   shifting and searching move one entry per cycle through that port.
//   each request is accepted in idle and walks the store (an insert shifts the
//   entries at and above its position up, a delete shifts the ones above it
//   down, a find stops at the first match); then an insert writes its value
//   and the result is handed off. a rejected request skips the walk. the
//   controller returns to idle after each result before it takes the next.
// reset:
//   i_rst_n low empties the list (count 0); no clearing pass, store contents
//   are only read below the count.
// stall:
//   a result waits in the output register; the next request can be taken and
//   worked on, and its result is held back until the register is free.
// ----------------------------------------------------------------------------
module positional_array_list #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [1:0] action, [8:2] position, [40:9] value_in, [47:41] zero
    input  logic [pal_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [1:0] status, [33:2] value_out, [40:34] found_position, [47:41] count,
    // [48] is_empty, [55:49] zero
    output logic [pal_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int OUT_USED = pal_pkg::STS_W + pal_pkg::VAL_W + pal_pkg::POS_W
                              + pal_pkg::CNT_W + 1;

    pal_pkg::t_cmd                      cmd;
    pal_pkg::t_stat                     stat;
    pal_pkg::t_action                   action;
    logic [pal_pkg::POS_W-1:0]          position;
    logic signed [pal_pkg::VAL_W-1:0]   value_in;
    logic [pal_pkg::STS_W-1:0]          status;
    logic signed [pal_pkg::VAL_W-1:0]   value_out;
    logic [pal_pkg::POS_W-1:0]          found_position;
    logic [pal_pkg::CNT_W-1:0]          count;
    logic                               is_empty;

    assign action   = pal_pkg::t_action'(i_s_tdata[1:0]);
    assign position = i_s_tdata[8:2];
    assign value_in = i_s_tdata[40:9];

    pal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pal_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (action),
        .i_position       (position),
        .i_value_in       (value_in),
        .o_status         (status),
        .o_value_out      (value_out),
        .o_found_position (found_position),
        .o_count          (count),
        .o_is_empty       (is_empty)
    );

    assign o_m_tdata = {{(pal_pkg::OUT_TDATA_W - OUT_USED){1'b0}},
                        is_empty, count, found_position, value_out, status};

endmodule

@@ rtl/pal_ram.sv @@
// ----------------------------------------------------------------------------
// pal_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/pal_ctrl.sv @@
// ----------------------------------------------------------------------------
// pal_ctrl
// request sequencer: accept, walk the store, final write, hand off result
// ----------------------------------------------------------------------------
module pal_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  pal_pkg::t_stat i_stat,
    output pal_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_tready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.req_fail ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = i_stat.is_insert ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                o_cmd.write_val = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to drain
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

    a_accept_leaves_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted but controller stayed idle");

    a_finish_needs_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> out_free)
        else $error("result loaded over an undelivered result");

    a_finish_sets_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished result not presented");

endmodule

@@ rtl/pal_datapath.sv @@
// ----------------------------------------------------------------------------
// pal_datapath
// entry store, walk pointers, range checks and result registers
// ----------------------------------------------------------------------------
module pal_datapath #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pal_pkg::t_cmd               i_cmd,
    output pal_pkg::t_stat              o_stat,
    input  pal_pkg::t_action            i_action,
    input  logic [pal_pkg::POS_W-1:0]   i_position,
    input  logic signed [pal_pkg::VAL_W-1:0] i_value_in,
    output logic [pal_pkg::STS_W-1:0]   o_status,
    output logic signed [pal_pkg::VAL_W-1:0] o_value_out,
    output logic [pal_pkg::POS_W-1:0]   o_found_position,
    output logic [pal_pkg::CNT_W-1:0]   o_count,
    output logic                        o_is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;

    pal_pkg::t_action           r_act;
    pal_pkg::t_status           r_status;
    logic [pal_pkg::VAL_W-1:0]  r_val;
    logic [CW-1:0]              r_pos_m1;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_ptr;
    logic [CW-1:0]              r_end;
    logic                       r_pend;
    logic [CW-1:0]              r_pend_addr;
    logic                       r_hit;
    logic [CW-1:0]              r_fpos;
    logic [pal_pkg::VAL_W-1:0]  r_vout;

    pal_pkg::t_status           chk_status;
    logic [XW-1:0]              pos_x;
    logic [XW-1:0]              cnt_x;
    logic [CW-1:0]              in_pos_m1;
    logic                       down;
    logic                       can_issue;
    logic                       issue;
    logic [CW-1:0]              rd_addr;
    logic                       shift_wr;
    logic [CW-1:0]              shift_wr_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [pal_pkg::VAL_W-1:0]  wr_data;
    logic [pal_pkg::VAL_W-1:0]  rd_data;
    logic                       req_ok;

    // request checks against the current count
    assign pos_x     = XW'(i_position);
    assign cnt_x     = XW'(r_count);
    assign in_pos_m1 = CW'(pos_x - 1'b1);

    always_comb begin
        chk_status = pal_pkg::ST_OK;
        case (i_action)
            pal_pkg::ACT_INSERT: begin
                if (i_position == '0 || pos_x > cnt_x + 1'b1) begin
                    chk_status = pal_pkg::ST_RANGE;
                end else if (r_count == CW'(CAPACITY)) begin
                    chk_status = pal_pkg::ST_FULL;
                end
            end
            pal_pkg::ACT_DELETE, pal_pkg::ACT_READ: begin
                if (i_position == '0 || pos_x > cnt_x) begin
                    chk_status = pal_pkg::ST_RANGE;
                end
            end
            default: begin
                chk_status = pal_pkg::ST_OK;
            end
        endcase
    end

    // insert walks down from the top, everything else walks up
    assign down      = (r_act == pal_pkg::ACT_INSERT);
    assign can_issue = down ? (r_ptr > r_end) : ((r_ptr < r_end) && !r_hit);
    assign issue     = i_cmd.walk && can_issue;
    assign rd_addr   = down ? (r_ptr - 1'b1) : r_ptr;

    always_comb begin
        shift_wr      = 1'b0;
        shift_wr_addr = r_pend_addr;
        if (r_pend) begin
            if (r_act == pal_pkg::ACT_INSERT) begin
                shift_wr      = 1'b1;
                shift_wr_addr = r_pend_addr + 1'b1;
            end else if (r_act == pal_pkg::ACT_DELETE && r_pend_addr != r_pos_m1) begin
                shift_wr      = 1'b1;
                shift_wr_addr = r_pend_addr - 1'b1;
            end
        end
    end

    assign wr_en   = shift_wr || i_cmd.write_val;
    assign wr_addr = i_cmd.write_val ? r_pos_m1[AW-1:0] : shift_wr_addr[AW-1:0];
    assign wr_data = i_cmd.write_val ? r_val : rd_data;

    pal_ram #(
        .WIDTH (pal_pkg::VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (rd_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign req_ok = (r_status == pal_pkg::ST_OK);

    always_comb begin
        n_count = r_count;
        if (req_ok && r_act == pal_pkg::ACT_INSERT) begin
            n_count = r_count + 1'b1;
        end else if (req_ok && r_act == pal_pkg::ACT_DELETE) begin
            n_count = r_count - 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_pend <= issue;
            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (r_pend && r_act == pal_pkg::ACT_FIND && !r_hit && rd_data == r_val) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= i_action;
            r_val    <= i_value_in;
            r_pos_m1 <= in_pos_m1;
            r_status <= chk_status;
            r_vout   <= '0;
            r_fpos   <= '0;
            case (i_action)
                pal_pkg::ACT_INSERT: begin
                    r_ptr <= r_count;
                    r_end <= in_pos_m1;
                end
                pal_pkg::ACT_DELETE: begin
                    r_ptr <= in_pos_m1;
                    r_end <= r_count;
                end
                pal_pkg::ACT_FIND: begin
                    r_ptr <= '0;
                    r_end <= r_count;
                end
                default: begin
                    r_ptr <= in_pos_m1;
                    r_end <= in_pos_m1 + 1'b1;
                end
            endcase
        end else begin
            if (issue) begin
                r_ptr       <= down ? (r_ptr - 1'b1) : (r_ptr + 1'b1);
                r_pend_addr <= rd_addr;
            end
            if (r_pend) begin
                if (r_act == pal_pkg::ACT_READ ||
                    (r_act == pal_pkg::ACT_DELETE && r_pend_addr == r_pos_m1)) begin
                    r_vout <= rd_data;
                end
                if (r_act == pal_pkg::ACT_FIND && !r_hit && rd_data == r_val) begin
                    r_fpos <= r_pend_addr + 1'b1;
                end
            end
        end
        if (i_cmd.finish) begin
            if (r_act == pal_pkg::ACT_FIND) begin
                o_status <= r_hit ? pal_pkg::ST_OK : pal_pkg::ST_MISSING;
            end else begin
                o_status <= r_status;
            end
            o_value_out      <= r_vout;
            o_found_position <= pal_pkg::POS_W'(r_fpos);
            o_count          <= pal_pkg::CNT_W'(n_count);
            o_is_empty       <= (n_count == '0);
        end
    end

    assign o_stat.req_fail  = (chk_status != pal_pkg::ST_OK);
    assign o_stat.walk_done = !can_issue && !r_pend;
    assign o_stat.is_insert = down;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_pend_follows_issue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(issue))
        else $error("read data marked without a read");

    a_single_writer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.write_val && shift_wr))
        else $error("value write collides with shift write");

endmodule
